/* rtl/ppts_pkg.sv */
`default_nettype none
package ppts_pkg;

   localparam int NUM_REGS = 8;
   localparam int CSR_IDX_W = 4;
   localparam int REG_W = 64;
   localparam int COORD_W = 32;
   // Width of the transformed homogeneous coordinates X, Y, Z and W.
   localparam int CLIP_W = 50;
   // Magnitude width of W.
   localparam int DEN_W = 49;
   // Quotient bits produced by the divider and the fraction shift of the result.
   localparam int DIV_Q_BITS = 34;
   localparam int DIV_FRAC = 15;
   // Divider registers: entry register, one register per quotient bit, saturation register.
   localparam int DIV_LAT = DIV_Q_BITS + 2;
   // Transform registers: input register, product register, column sum register.
   localparam int XF_LAT = 3;

   typedef logic [REG_W-1:0] reg_array_type [NUM_REGS];

   typedef struct packed {
      logic signed [CLIP_W-1:0] cx;
      logic signed [CLIP_W-1:0] cy;
      logic signed [CLIP_W-1:0] cz;
      logic signed [CLIP_W-1:0] cw;
   } clip_type;

   localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

endpackage
`default_nettype wire

/* rtl/ppts_xform.sv */
`default_nettype none
module ppts_xform (
   input  wire logic                         clock,
   input  wire logic                         en,
   input  wire logic [3*ppts_pkg::COORD_W-1:0] point,
   input  wire ppts_pkg::reg_array_type      regs,
   output ppts_pkg::clip_type                clip
);

   logic signed [ppts_pkg::COORD_W-1:0] p_ff [3];
   logic signed [2*ppts_pkg::COORD_W-1:0] prod_ff [3][4];
   logic signed [ppts_pkg::CLIP_W-1:0] col_ff [4];

   function automatic logic signed [ppts_pkg::COORD_W-1:0] ent(
      input ppts_pkg::reg_array_type r, input int row, input int col);
      logic [ppts_pkg::REG_W-1:0] w;
      w = r[row*2 + col/2];
      return (col % 2 == 1) ? $signed(w[63:32]) : $signed(w[31:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= $signed(point[i*ppts_pkg::COORD_W +: ppts_pkg::COORD_W]);
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 4; j++) begin
               prod_ff[i][j] <= p_ff[i] * ent(regs, i, j);
            end
         end
         // Each product drops 16 fraction bits, rounding toward minus infinity.
         for (int j = 0; j < 4; j++) begin
            col_ff[j] <= ppts_pkg::CLIP_W'(ent(regs, 3, j))
                       + ppts_pkg::CLIP_W'($signed(prod_ff[0][j][63:16]))
                       + ppts_pkg::CLIP_W'($signed(prod_ff[1][j][63:16]))
                       + ppts_pkg::CLIP_W'($signed(prod_ff[2][j][63:16]));
         end
      end
   end

   assign clip.cx = col_ff[0];
   assign clip.cy = col_ff[1];
   assign clip.cz = col_ff[2];
   assign clip.cw = col_ff[3];

endmodule
`default_nettype wire

/* rtl/ppts_sdiv.sv */
`default_nettype none
module ppts_sdiv #(
   parameter int NUM_W = 62
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [NUM_W-1:0]              num_mag,
   input  wire logic [ppts_pkg::DEN_W-1:0]    den_mag,
   input  wire logic                          neg,
   output logic [ppts_pkg::COORD_W-1:0]       result
);

   localparam int Q = ppts_pkg::DIV_Q_BITS;
   localparam int DW = ppts_pkg::DEN_W;
   localparam int HI_SH = Q - ppts_pkg::DIV_FRAC;
   localparam int CW = NUM_W + DW;

   logic [DW-1:0] rem_ff [Q+1];
   logic [DW-1:0] den_ff [Q+1];
   logic [Q-1:0]  tail_ff [Q+1];
   logic [Q-1:0]  quo_ff [Q+1];
   logic          neg_ff [Q+1];
   logic          ovf_ff [Q+1];
   logic [ppts_pkg::COORD_W-1:0] res_ff;

   logic [CW-1:0] hi_w;
   logic [CW-1:0] den_w;
   logic          ovf;

   // The quotient of (num << 15) / den must fit in Q bits, else it saturates.
   assign hi_w = CW'(num_mag >> HI_SH);
   assign den_w = CW'(den_mag);
   assign ovf = hi_w >= den_w;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= ovf ? '0 : hi_w[DW-1:0];
         den_ff[0]  <= den_mag;
         tail_ff[0] <= Q'({num_mag[HI_SH-1:0], {ppts_pkg::DIV_FRAC{1'b0}}});
         quo_ff[0]  <= '0;
         neg_ff[0]  <= neg;
         ovf_ff[0]  <= ovf;
      end
   end

   for (genvar s = 1; s <= Q; s++) begin : g_step
      logic [DW:0] r2;
      logic [DW:0] diff;
      logic        ge;
      assign r2 = {rem_ff[s-1], tail_ff[s-1][Q-1]};
      assign diff = r2 - {1'b0, den_ff[s-1]};
      assign ge = r2 >= {1'b0, den_ff[s-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? diff[DW-1:0] : r2[DW-1:0];
            den_ff[s]  <= den_ff[s-1];
            tail_ff[s] <= {tail_ff[s-1][Q-2:0], 1'b0};
            quo_ff[s]  <= {quo_ff[s-1][Q-2:0], ge};
            neg_ff[s]  <= neg_ff[s-1];
            ovf_ff[s]  <= ovf_ff[s-1];
         end
      end
   end

   logic [Q-1:0] neg_q;
   assign neg_q = -quo_ff[Q];

   always_ff @(posedge clock) begin
      if (en) begin
         if (neg_ff[Q]) begin
            res_ff <= (ovf_ff[Q] || quo_ff[Q] > Q'(ppts_pkg::SAT_MIN))
                    ? ppts_pkg::SAT_MIN : neg_q[ppts_pkg::COORD_W-1:0];
         end else begin
            res_ff <= (ovf_ff[Q] || quo_ff[Q] > Q'(ppts_pkg::SAT_MAX))
                    ? ppts_pkg::SAT_MAX : quo_ff[Q][ppts_pkg::COORD_W-1:0];
         end
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire

/* rtl/project_point_to_screen_top.sv */
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_tvalid/req_tready  tdata: world_x, world_y, world_z
// rsp       out        rsp_tvalid/rsp_tready  tdata: screen_x, screen_y; tuser: visible
// csr       in         csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One item enters per clock while rsp is not stalled; its result passes through
// 42 register stages: three in the transform, three for the depth test and
// scaling, and 36 in the pipelined divider, which resolves one quotient bit
// per stage. Reset clears every valid bit and loads the identity matrix.
// A stall on rsp freezes the whole pipeline; a skid register at the input still
// takes one more item, so nothing is lost or repeated.
module project_point_to_screen_top #(
   parameter int SCREEN_WIDTH = 1280,
   parameter int SCREEN_HEIGHT = 720
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // world_x [31:0], world_y [63:32], world_z [95:64]
   input  wire logic [95:0]                    req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // screen_x [31:0], screen_y [63:32]
   output logic [63:0]                         rsp_tdata,
   // visible [0]
   output logic [0:0]                          rsp_tuser,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [ppts_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ppts_pkg::REG_W-1:0]     csr_data
);

   // Width that holds either screen dimension as an unsigned number.
   localparam int DIM_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int DIM_W = $clog2(DIM_MAX + 1);
   localparam int SUM_W = ppts_pkg::CLIP_W + 1;
   localparam int PROD_W = SUM_W + DIM_W + 1;
   localparam int NUM_W = SUM_W + DIM_W;
   localparam int PIPE_LEN = ppts_pkg::XF_LAT + 3 + ppts_pkg::DIV_LAT;
   localparam int CW = ppts_pkg::CLIP_W;

   ppts_pkg::reg_array_type regs_ff;

   // Configuration writes are taken at once; indexes beyond the matrix are ignored.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= ppts_pkg::REG_RESET;
      end else if (csr_valid && csr_index < ppts_pkg::CSR_IDX_W'(ppts_pkg::NUM_REGS)) begin
         regs_ff[csr_index[2:0]] <= csr_data;
      end
   end

   // Input skid and pipeline advance.
   logic        skid_v_ff;
   logic [95:0] skid_ff;
   logic        v_ff [PIPE_LEN];
   logic        vis_ff [ppts_pkg::XF_LAT:PIPE_LEN-1];
   logic        en;
   logic        src_v;
   logic [95:0] src_data;

   assign en = !v_ff[PIPE_LEN-1] || rsp_tready;
   assign req_tready = !skid_v_ff;
   assign src_v = skid_v_ff || (req_tvalid && req_tready);
   assign src_data = skid_v_ff ? skid_ff : req_tdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_v_ff <= 1'b0;
         for (int i = 0; i < PIPE_LEN; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         skid_v_ff <= 1'b0;
         v_ff[0] <= src_v;
         for (int i = 1; i < PIPE_LEN; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end else if (req_tvalid && req_tready) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_tvalid && req_tready) begin
         skid_ff <= src_data;
      end
   end

   ppts_pkg::clip_type clip;

   ppts_xform u_xform (
      .clock (clock),
      .en    (en),
      .point (src_data),
      .regs  (regs_ff),
      .clip  (clip)
   );

   // Stage A: depth test and the screen-space numerators before scaling.
   logic signed [SUM_W-1:0] sumx_ff, sumy_ff;
   logic signed [CW-1:0]    wa_ff, wb_ff;
   logic                    vis_a;

   always_comb begin
      if (clip.cw > 0) begin
         vis_a = clip.cz >= 0 && clip.cz <= clip.cw;
      end else if (clip.cw < 0) begin
         vis_a = clip.cz <= 0 && clip.cz >= clip.cw;
      end else begin
         vis_a = 1'b0;
      end
   end

   // Stage B: scaling by the screen size. Stage C: magnitudes and result sign.
   logic signed [PROD_W-1:0] numx_ff, numy_ff;
   logic [NUM_W-1:0]         anx_ff, any_ff;
   logic [ppts_pkg::DEN_W-1:0] aw_ff;
   logic                     negx_ff, negy_ff;
   logic signed [PROD_W-1:0] numx_abs, numy_abs;
   logic signed [CW-1:0]     w_abs;

   assign numx_abs = numx_ff < 0 ? -numx_ff : numx_ff;
   assign numy_abs = numy_ff < 0 ? -numy_ff : numy_ff;
   assign w_abs = wb_ff < 0 ? -wb_ff : wb_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sumx_ff <= SUM_W'(clip.cw) + SUM_W'(clip.cx);
         sumy_ff <= SUM_W'(clip.cw) - SUM_W'(clip.cy);
         wa_ff   <= clip.cw;
         numx_ff <= $signed({1'b0, DIM_W'(SCREEN_WIDTH)}) * sumx_ff;
         numy_ff <= $signed({1'b0, DIM_W'(SCREEN_HEIGHT)}) * sumy_ff;
         wb_ff   <= wa_ff;
         anx_ff  <= numx_abs[NUM_W-1:0];
         any_ff  <= numy_abs[NUM_W-1:0];
         aw_ff   <= w_abs[ppts_pkg::DEN_W-1:0];
         negx_ff <= (numx_ff < 0) != (wb_ff < 0);
         negy_ff <= (numy_ff < 0) != (wb_ff < 0);
         vis_ff[ppts_pkg::XF_LAT] <= vis_a;
         for (int i = ppts_pkg::XF_LAT + 1; i < PIPE_LEN; i++) begin
            vis_ff[i] <= vis_ff[i-1];
         end
      end
   end

   logic [ppts_pkg::COORD_W-1:0] sx, sy;

   ppts_sdiv #(.NUM_W(NUM_W)) u_div_x (
      .clock   (clock),
      .en      (en),
      .num_mag (anx_ff),
      .den_mag (aw_ff),
      .neg     (negx_ff),
      .result  (sx)
   );

   ppts_sdiv #(.NUM_W(NUM_W)) u_div_y (
      .clock   (clock),
      .en      (en),
      .num_mag (any_ff),
      .den_mag (aw_ff),
      .neg     (negy_ff),
      .result  (sy)
   );

   // A point that is not visible reports zero coordinates.
   assign rsp_tvalid = v_ff[PIPE_LEN-1];
   assign rsp_tuser = vis_ff[PIPE_LEN-1];
   assign rsp_tdata = vis_ff[PIPE_LEN-1] ? {sy, sx} : 64'h0;

endmodule
`default_nettype wire

/* rtl/ppts_checker.sv */
`default_nettype none
module ppts_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'h0)
      else $error("hidden point with nonzero coordinates");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_skid_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tvalid && !rsp_tready |=> !req_tready)
      else $error("input taken twice while output stalled");

endmodule

bind project_point_to_screen_top ppts_sva u_ppts_sva (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

/* test/ppts_checker.sv */
`timescale 1ns / 100ps
`default_nettype none
module ppts_checker #(
   parameter int SCREEN_WIDTH = 1280,
   parameter int SCREEN_HEIGHT = 720
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [95:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [63:0] rsp_tdata,
   input  wire logic [0:0]  rsp_tuser,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [ppts_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ppts_pkg::REG_W-1:0]     csr_data,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic        vis;
      logic [31:0] sx;
      logic [31:0] sy;
   } screen_pt_type;

   logic [ppts_pkg::REG_W-1:0] matrix [ppts_pkg::NUM_REGS];
   screen_pt_type              screen_q [$];

   function automatic longint mat_entry(int r, int c);
      logic [63:0] w;
      w = matrix[r*2 + c/2];
      return (c % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
   endfunction

   // num * 2^15 / den truncated toward zero, saturated to 32 bits.
   function automatic logic [31:0] ratio_q16(longint num, longint den);
      logic        neg;
      logic [63:0] an, ad, q0, rm, mag;
      neg = (num < 0) != (den < 0);
      an = num < 0 ? -num : num;
      ad = den < 0 ? -den : den;
      q0 = an / ad;
      rm = an % ad;
      if (q0 > 64'h1_0000_0000) mag = 64'h2_0000_0000;
      else mag = (q0 << 15) + ((rm << 15) / ad);
      if (neg) return (mag > 64'h8000_0000) ? ppts_pkg::SAT_MIN : 32'(-mag);
      return (mag > 64'h7FFF_FFFF) ? ppts_pkg::SAT_MAX : mag[31:0];
   endfunction

   function automatic screen_pt_type project_point(logic [95:0] d);
      longint        p [3];
      longint        cc [4];
      longint        acc;
      screen_pt_type res;
      for (int i = 0; i < 3; i++) p[i] = longint'(signed'(d[32*i +: 32]));
      for (int j = 0; j < 4; j++) begin
         acc = mat_entry(3, j);
         for (int i = 0; i < 3; i++) acc += (p[i] * mat_entry(i, j)) >>> 16;
         cc[j] = acc;
      end
      if (cc[3] > 0) res.vis = cc[2] >= 0 && cc[2] <= cc[3];
      else if (cc[3] < 0) res.vis = cc[2] <= 0 && cc[2] >= cc[3];
      else res.vis = 1'b0;
      res.sx = '0;
      res.sy = '0;
      if (res.vis) begin
         res.sx = ratio_q16(longint'(SCREEN_WIDTH) * (cc[3] + cc[0]), cc[3]);
         res.sy = ratio_q16(longint'(SCREEN_HEIGHT) * (cc[3] - cc[1]), cc[3]);
      end
      return res;
   endfunction

   assign pending = screen_q.size();

   always @(posedge clock) begin
      screen_pt_type want;
      if (reset) begin
         for (int i = 0; i < ppts_pkg::NUM_REGS; i++) matrix[i] <= ppts_pkg::REG_RESET[i];
         screen_q.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready && csr_index < ppts_pkg::NUM_REGS)
            matrix[csr_index[2:0]] <= csr_data;
         if (req_tvalid && req_tready) screen_q.push_back(project_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (screen_q.size() == 0) begin
               $display("%0t: unexpected result vis=%0d sx=%h sy=%h", $time,
                        rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32]);
               errors <= errors + 1;
            end else begin
               want = screen_q.pop_front();
               if (want.vis !== rsp_tuser[0] || want.sx !== rsp_tdata[31:0] ||
                   want.sy !== rsp_tdata[63:32]) begin
                  $display("%0t: mismatch expected vis=%0d sx=%h sy=%h, got vis=%0d sx=%h sy=%h",
                           $time, want.vis, want.sx, want.sy,
                           rsp_tuser[0], rsp_tdata[31:0], rsp_tdata[63:32]);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int WATCHDOG = 20000;
   localparam int LATENCY = 42;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [ppts_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ppts_pkg::REG_W-1:0]     csr_data = '0;
   int          errors, pending;
   int          idle_cycles = 0;
   // While set, neither side idles at random.
   logic        steady = 1'b0;

   always #10 clock = ~clock;

   project_point_to_screen_top dut (.*);

   ppts_checker chk (.*);

   // The receiver stalls with a probability of about 30 percent, except in the steady stretch.
   always @(posedge clock) rsp_tready <= steady || ($urandom_range(99) >= 30);

   // The watchdog counts cycles in which nothing at all is accepted.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic write_reg(int idx, logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= ppts_pkg::CSR_IDX_W'(idx);
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Loads a whole matrix; the block must be idle beforehand.
   task automatic load_matrix(logic [63:0] m [8]);
      for (int i = 0; i < 8; i++) write_reg(i, m[i]);
      csr_valid <= 1'b0;
   endtask

   // Sends one point; valid stays high between back-to-back items.
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   function automatic logic [31:0] q16(int whole);
      return 32'(whole) << 16;
   endfunction

   // World coordinates mostly of moderate size, sometimes of any value.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(200)) - 100) << 16;
         default: return 32'(signed'($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
      endcase
   endfunction

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(32'h0004_0000)) - 32'sh0002_0000);
         default: return ($urandom_range(1) ? 32'h0001_0000 : 32'h0);
      endcase
   endfunction

   initial begin
      logic [63:0] m [8];
      logic [31:0] c, n, f;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Identity matrix after reset: depth equals z, so z in 0..1 is visible.
      send_point(32'h0, 32'h0, 32'h0);
      send_point(q16(1), q16(-1), q16(1));
      send_point(32'h0, 32'h0, 32'h0001_0001);
      send_point(32'h0, 32'h0, 32'hFFFF_FFFF);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000);
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // Every sender hold-off: wait until all results have come.
      drain();

      // A zero W column: nothing is visible.
      m = '{64'h0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
            64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0};
      load_matrix(m);
      send_point(q16(3), q16(4), q16(0));
      send_point(32'h0, 32'h0, 32'h0);
      drain();

      // Negative W with depth inside its range, tiny W for saturation, and
      // both extreme entry values in register 6.
      m = '{64'hFFFF_0000_0001_0000, 64'hFFFF_FFFF_0000_0000, 64'h0001_0000_FFFF_0000,
            64'h0000_0001_0000_0000, 64'h0, 64'h0000_0000_FFFF_8000,
            64'h7FFF_FFFF_8000_0000, 64'hFFFF_0000_0000_0000};
      load_matrix(m);
      send_point(q16(1), q16(1), q16(1));
      send_point(q16(0), q16(0), q16(-1));
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h0001_0000, 32'h0, 32'h0);
      drain();

      for (int i = 0; i < 8; i++) m[i] = 64'hFFFF_FFFF_FFFF_FFFF;
      load_matrix(m);
      send_point(32'hFFFF_FFFF, 32'h0, 32'h7FFF_FFFF);
      send_point(q16(2), q16(-2), q16(5));
      drain();

      // Random phases: a perspective-like matrix with random content in most,
      // fully random matrices in the rest.
      for (int ph = 0; ph < 10; ph++) begin
         for (int i = 0; i < 8; i++) m[i] = {rand_entry(), rand_entry()};
         if (ph % 3 != 2) begin
            c = 32'h0001_0000 + ($urandom_range(32'h0002_0000));
            n = $urandom_range(32'h0000_8000);
            f = 32'h0001_0000 + $urandom_range(32'h0010_0000);
            m[0] = {32'h0, c};
            m[2] = {c, 32'h0};
            m[4] = {32'h0, 32'h0};
            m[5] = {32'h0001_0000, f};
            m[6] = {rand_entry(), rand_entry()};
            m[7] = {32'h0, 32'(-(longint'(n) * f) >>> 16)};
         end
         load_matrix(m);
         steady = (ph == 4);
         for (int k = 0; k < 100; k++) begin
            if (ph % 3 != 2 && $urandom_range(9) < 8)
               send_point(rand_coord(), rand_coord(),
                          32'($urandom_range(32'h0040_0000)) - 32'h0004_0000);
            else
               send_point(rand_coord(), rand_coord(), rand_coord());
         end
         steady = 1'b0;
         drain();
      end

      // Restore the reset matrix and finish with fully random points.
      load_matrix(ppts_pkg::REG_RESET);
      for (int k = 0; k < 25; k++) send_point($urandom, $urandom, $urandom);
      drain();

      if (errors == 0 && pending == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
`default_nettype wire
